// ===== sv/pid_positional_clamped_integral_core_assert.svh =====
// Assertion macros shared by the PID core checks.
`ifndef PID_POSITIONAL_CLAMPED_INTEGRAL_CORE_ASSERT_SVH
`define PID_POSITIONAL_CLAMPED_INTEGRAL_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PIDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pidc_pkg.sv =====
// Package with widths, register codes and shared types of the PID core.
`default_nettype none
package pidc_pkg;

  localparam int FRAC_BITS  = 4;
  localparam int GAIN_FRAC  = 8;
  localparam int BASE_LIMIT = 2000;

  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 22;
  localparam int INT_W   = 24;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int PKP_W   = GAIN_W + ERR_W;
  localparam int PKI_W   = GAIN_W + INT_W;
  localparam int PKD_W   = GAIN_W + DIFF_W;
  localparam int SUM_W   = PKI_W + 2;
  localparam int SHIFT   = FRAC_BITS + GAIN_FRAC;
  localparam int Q_W     = SUM_W - SHIFT;
  localparam int DRV_W   = 16;
  localparam int DRV_MAX = 32767;
  localparam int DRV_MIN = -32768;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(BASE_LIMIT * (1 << FRAC_BITS));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP             = 8'd0,
    REG_KI             = 8'd1,
    REG_KD             = 8'd2,
    REG_INTEGRAL_LIMIT = 8'd3
  } pidc_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]         integral_limit;
  } pidc_gains_t;

  typedef struct packed {
    logic                    valid;
    logic signed [PKP_W-1:0] p_kp;
    logic signed [PKI_W-1:0] p_ki;
    logic signed [PKD_W-1:0] p_kd;
  } pidc_prod_t;

  typedef struct packed {
    logic signed [INT_W-1:0] integral_sum;
    logic signed [ERR_W-1:0] previous_error;
  } pidc_state_t;

endpackage
`default_nettype wire

// ===== sv/pidc_err_if.sv =====
// Stream interface carrying one error sample per word.
`default_nettype none
interface pidc_err_if
  import pidc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [ERR_W-1:0] error_sample;

  modport source (output valid, output error_sample, input ready);
  modport sink (input valid, input error_sample, output ready);
endinterface
`default_nettype wire

// ===== sv/pidc_drive_if.sv =====
// Stream interface carrying one drive value per word.
`default_nettype none
interface pidc_drive_if
  import pidc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink (input valid, input drive_value, output ready);
endinterface
`default_nettype wire

// ===== sv/pidc_cfg_if.sv =====
// Register write channel carrying an index and a data word.
`default_nettype none
interface pidc_cfg_if
  import pidc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pidc_cfg_regs.sv =====
// Configuration register file holding the gains and the integral limit.
`default_nettype none
module pidc_cfg_regs
  import pidc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  pidc_cfg_if.sink    cfg,
  output pidc_gains_t gains
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.kp             <= '0;
      gains.ki             <= '0;
      gains.kd             <= '0;
      gains.integral_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KP:             gains.kp <= signed'(cfg.data[GAIN_W-1:0]);
        REG_KI:             gains.ki <= signed'(cfg.data[GAIN_W-1:0]);
        REG_KD:             gains.kd <= signed'(cfg.data[GAIN_W-1:0]);
        REG_INTEGRAL_LIMIT: gains.integral_limit <= cfg.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/pidc_mult.sv =====
// Input stage: integral update, clamp, and the three gain products.
`default_nettype none
module pidc_mult
  import pidc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  pidc_err_if.sink    sample,
  input  pidc_gains_t gains,
  input  logic        s1_ready,
  output pidc_prod_t  prod,
  output pidc_state_t state
);

  logic                     accept;
  logic signed [ERR_W-1:0]  err;
  logic signed [INT_W-1:0]  acc;
  logic signed [INT_W-1:0]  lim_pos;
  logic signed [INT_W-1:0]  lim_neg;
  logic signed [INT_W-1:0]  integral_sum_next;
  logic signed [DIFF_W-1:0] diff;

  assign sample.ready = !prod.valid || s1_ready;
  assign accept       = sample.valid && sample.ready;
  assign err          = sample.error_sample;

  // The output uses the unclamped sum; only the stored copy is clamped.
  assign acc     = INT_W'(state.integral_sum) + INT_W'(err);
  assign lim_pos = signed'(INT_W'(gains.integral_limit));
  assign lim_neg = -lim_pos;
  assign diff    = DIFF_W'(err) - DIFF_W'(state.previous_error);

  always_comb begin
    if (acc > lim_pos) begin
      integral_sum_next = lim_pos;
    end else if (acc < lim_neg) begin
      integral_sum_next = lim_neg;
    end else begin
      integral_sum_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid           <= 1'b0;
      state.integral_sum   <= '0;
      state.previous_error <= '0;
    end else if (accept) begin
      prod.valid           <= 1'b1;
      prod.p_kp            <= PKP_W'(gains.kp) * PKP_W'(err);
      prod.p_ki            <= PKI_W'(gains.ki) * PKI_W'(acc);
      prod.p_kd            <= PKD_W'(gains.kd) * PKD_W'(diff);
      state.integral_sum   <= integral_sum_next;
      state.previous_error <= err;
    end else if (s1_ready) begin
      prod.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pidc_out.sv =====
// Output stage: sum of products, scaling toward zero, saturation, result register.
`default_nettype none
module pidc_out
  import pidc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  pidc_prod_t  prod,
  output logic        s1_ready,
  pidc_drive_if.source drive
);

  logic signed [SUM_W-1:0] total;
  logic signed [Q_W-1:0]   quot;
  logic signed [Q_W-1:0]   quot_adj;
  logic                    corr;
  logic signed [DRV_W-1:0] sat;

  assign s1_ready = !drive.valid || drive.ready;

  assign total = SUM_W'(prod.p_kp) + SUM_W'(prod.p_ki) + SUM_W'(prod.p_kd);
  assign quot  = total[SUM_W-1:SHIFT];
  // An arithmetic shift rounds down; a negative sum with dropped bits moves up by one.
  assign corr     = total[SUM_W-1] && (|total[SHIFT-1:0]);
  assign quot_adj = quot + signed'(Q_W'(corr));

  always_comb begin
    if (quot_adj > Q_W'(DRV_MAX)) begin
      sat = DRV_W'(DRV_MAX);
    end else if (quot_adj < Q_W'(DRV_MIN)) begin
      sat = DRV_W'(DRV_MIN);
    end else begin
      sat = quot_adj[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive.valid <= 1'b0;
    end else if (s1_ready) begin
      drive.valid <= prod.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && prod.valid) begin
      drive.drive_value <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pid_positional_clamped_integral_core.sv =====
// Top level of the positional PID core with a clamped integral.
`default_nettype none
// This core runs a positional PID loop on one error word per control tick and
// returns one drive word for each. It accepts a new error word in every cycle
// while the output is not stalled. The error word passes the three gain
// multipliers into the product register, and the scaling adder then moves it
// into the output register. Sustained throughput is one word per cycle as long
// as the downstream side takes results; a stalled output holds its word, and
// one further word waits in the product register before the input stops taking
// words. The error word and the integral carry four fractional bits and the
// gains are signed Q8.8. The integral is updated in the same cycle as the
// error word is taken, so back-to-back words see the correct history. The
// output uses the integral before it is clamped; only the stored integral is
// clamped to plus or minus integral_limit. The sum of products is divided by
// 4096 with truncation toward zero and saturated to 16 signed bits. Registers
// are written through the cfg channel, which is always ready: index 0 is kp,
// 1 is ki, 2 is kd and 3 is integral_limit, other indexes are ignored, and
// data bits above a register's width are dropped. After reset the gains are
// zero and the limit is 32000 (2000 in whole units). Registers should only be
// written while no word is in flight.
module pid_positional_clamped_integral_core
  import pidc_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  pidc_cfg_if.sink     cfg,
  pidc_err_if.sink     sample,
  pidc_drive_if.source drive
);

`include "pid_positional_clamped_integral_core_assert.svh"

  pidc_gains_t gains;
  pidc_prod_t  prod;
  pidc_state_t state;
  logic        s1_ready;
  logic        in_accept;

  // Gains and limit live in a small register file.
  pidc_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .gains (gains)
  );

  // The first stage owns the loop state and forms the three products.
  pidc_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .gains    (gains),
    .s1_ready (s1_ready),
    .prod     (prod),
    .state    (state)
  );

  // The second stage scales, saturates and presents the drive word.
  pidc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .prod     (prod),
    .s1_ready (s1_ready),
    .drive    (drive)
  );

  assign in_accept = sample.valid && sample.ready;

  // The stored integral never leaves the limit that was in force at the update.
  `PIDC_ASSERT_NEXT(a_integral_clamped, in_accept,
    (state.integral_sum <= signed'(INT_W'($past(gains.integral_limit)))) &&
    (state.integral_sum >= -signed'(INT_W'($past(gains.integral_limit)))),
    "stored integral outside the clamp limit")

  // An accepted word always lands in the product register.
  `PIDC_ASSERT_NEXT(a_accept_fills_stage, in_accept, prod.valid,
    "accepted word did not reach the product stage")

  // While the output is stalled, a waiting product word must not change or vanish.
  `PIDC_ASSERT_NEXT(a_stage_holds, prod.valid && drive.valid && !drive.ready,
    prod.valid && $stable(prod),
    "product stage changed during an output stall")

  // The derivative history follows the last accepted error word.
  `PIDC_ASSERT_NEXT(a_prev_error, in_accept,
    state.previous_error == $past(sample.error_sample),
    "previous error not taken from the accepted word")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the positional PID core with a clamped integral.
`timescale 1ns / 100ps
module testbench
  import pidc_pkg::*;
;
  // Number of registers in the write map; any index at or above it is ignored.
  localparam int NUM_REGS = 4;
  // Length of the deliberate output stall that fills the core and backs up its input.
  localparam int SQUEEZE_CYCLES = 40;
  // Cycles without any handshake after which the run is declared hung.
  localparam int HANG_LIMIT = 500;
  // Cycles to let pass after the last result before the run ends.
  localparam int TAIL_CYCLES = 4;

  typedef enum logic {WORD_ERROR, WORD_REG} stim_kind_t;

  typedef struct packed {
    stim_kind_t                kind;
    logic [CFG_IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0]     data;
    logic signed [ERR_W-1:0]   err;
  } stim_word_t;

  typedef enum int {SPREAD_FULL, SPREAD_SMALL, SPREAD_WINDUP} spread_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pidc_cfg_if   cfg_ch ();
  pidc_err_if   sample_ch ();
  pidc_drive_if drive_ch ();

  pid_positional_clamped_integral_core uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .drive  (drive_ch)
  );

  // Words waiting to be offered to the core, in order: register writes and error samples.
  stim_word_t stim_q[$];
  // Drive values the core owes us, oldest first.
  logic signed [DRV_W-1:0] due_drive_q[$];

  // Our own copy of the controller: registers, running integral and last error.
  pidc_gains_t             gains_q;
  logic signed [INT_W-1:0] integ_q;
  logic signed [ERR_W-1:0] prev_err_q;

  // Shared knobs set by the sequence and read by the clocked processes.
  // idle_odds of zero means no idling on either side; otherwise a burst
  // starts with a chance of one in idle_odds.
  int idle_odds   = 0;
  int squeeze_req = 0;

  int fault_count   = 0;
  int words_checked = 0;
  int regs_written  = 0;

  // Driver and monitor working variables.
  int                      gap_left;
  int                      stall_left;
  int                      squeeze_seen;
  int                      hang_count;
  logic                    err_go;
  logic                    reg_go;
  stim_word_t              head;
  logic signed [DRV_W-1:0] want;

  // The clock starts low and rises first at 10 ns.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Computes the drive value of one tick and moves our controller state on.
  // The output sees the integral before the clamp; only the stored copy is
  // clamped, and the error is kept for the next derivative term.
  function automatic logic signed [DRV_W-1:0] advance_pid(input logic signed [ERR_W-1:0] e);
    longint acc;
    longint total;
    longint scaled;
    longint lim;
    longint ev;
    longint pv;
    ev  = e;
    pv  = prev_err_q;
    acc = longint'(integ_q) + ev;
    lim = longint'(gains_q.integral_limit);
    total = longint'($signed(gains_q.kp)) * ev
          + longint'($signed(gains_q.ki)) * acc
          + longint'($signed(gains_q.kd)) * (ev - pv);
    // Division in SystemVerilog truncates toward zero, as the core must.
    scaled = total / (longint'(1) << SHIFT);
    if (scaled > DRV_MAX) scaled = DRV_MAX;
    if (scaled < DRV_MIN) scaled = DRV_MIN;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    integ_q    = INT_W'(acc);
    prev_err_q = e;
    return DRV_W'(scaled);
  endfunction

  // Applies one register write; bits above the register width are dropped
  // and an index outside the map changes nothing.
  function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_KP:             gains_q.kp = d[GAIN_W-1:0];
      REG_KI:             gains_q.ki = d[GAIN_W-1:0];
      REG_KD:             gains_q.kd = d[GAIN_W-1:0];
      REG_INTEGRAL_LIMIT: gains_q.integral_limit = d[LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // Driver. It offers the head of the pending queue on whichever channel it
  // belongs to and holds the word until the core takes it. Every accepted
  // error word is run through our controller right away, so the expected
  // drive value is queued in acceptance order. Each signal gets one
  // nonblocking assignment per edge, so a valid that stays high for
  // back-to-back words is never dropped and raised in the same step.
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid        <= 1'b0;
      sample_ch.error_sample <= '0;
      cfg_ch.valid           <= 1'b0;
      cfg_ch.index           <= '0;
      cfg_ch.data            <= '0;
      gap_left                = 0;
      gains_q.kp              = '0;
      gains_q.ki              = '0;
      gains_q.kd              = '0;
      gains_q.integral_limit  = LIMIT_RESET;
      integ_q                 = '0;
      prev_err_q              = '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        due_drive_q.push_back(advance_pid(sample_ch.error_sample));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        load_reg(cfg_ch.index, cfg_ch.data);
        regs_written++;
      end
      err_go = sample_ch.valid && !sample_ch.ready;
      reg_go = cfg_ch.valid && !cfg_ch.ready;
      if (!err_go && !reg_go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          head = stim_q.pop_front();
          if (head.kind == WORD_REG) begin
            reg_go        = 1'b1;
            cfg_ch.index <= head.index;
            cfg_ch.data  <= head.data;
          end else begin
            err_go                  = 1'b1;
            sample_ch.error_sample <= head.err;
          end
          // An idle burst may follow any word, so gaps land on every phase.
          if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap_left = $urandom_range(1, 5);
          end
        end
      end
      sample_ch.valid <= err_go;
      cfg_ch.valid    <= reg_go;
    end
  end

  // Monitor. It compares every accepted drive word with the oldest
  // expectation, and it plays the downstream side: short random stalls, and
  // on request one long hold-off that lets the core fill up and push back.
  always @(posedge clk) begin
    if (rst) begin
      drive_ch.ready <= 1'b0;
      stall_left      = 0;
      squeeze_seen    = 0;
    end else begin
      if (drive_ch.valid && drive_ch.ready) begin
        if (due_drive_q.size() == 0) begin
          $display("%0t: drive_value %0d arrived with nothing expected", $time,
                   drive_ch.drive_value);
          fault_count++;
        end else begin
          want = due_drive_q.pop_front();
          words_checked++;
          if (drive_ch.drive_value !== want) begin
            $display("%0t: drive_value expected %0d, actual %0d", $time, want,
                     drive_ch.drive_value);
            fault_count++;
          end
        end
      end
      if (squeeze_seen != squeeze_req) begin
        squeeze_seen = squeeze_req;
        stall_left   = SQUEEZE_CYCLES;
      end else if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        drive_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        drive_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long stretch with no handshake on any channel means the core hung.
  always @(posedge clk) begin
    if (rst) begin
      hang_count = 0;
    end else if ((sample_ch.valid && sample_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                 (drive_ch.valid && drive_ch.ready)) begin
      hang_count = 0;
    end else begin
      hang_count++;
      if (hang_count >= HANG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic bit all_quiet();
    return stim_q.size() == 0 && !sample_ch.valid && !cfg_ch.valid && due_drive_q.size() == 0;
  endfunction

  task automatic push_error(input logic signed [ERR_W-1:0] e);
    stim_q.push_back('{kind: WORD_ERROR, index: '0, data: '0, err: e});
  endtask

  task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    stim_q.push_back('{kind: WORD_REG, index: idx, data: d, err: '0});
  endtask

  // Registers may only change with nothing in flight. Every error word gives
  // exactly one result, so an empty expectation queue means the pipeline is
  // empty; the short pause is only a margin.
  task automatic wait_quiet();
    while (!all_quiet()) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // A gain with junk in the upper data bits: extremes, zero, modest values or anything.
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 6))
      0: w[GAIN_W-1:0] = 16'h7FFF;
      1: w[GAIN_W-1:0] = 16'h8000;
      2: w[GAIN_W-1:0] = 16'h0000;
      3, 4: begin
        w[GAIN_W-1:0] = GAIN_W'($urandom_range(0, 1024));
        if ($urandom_range(0, 1) == 1) w[GAIN_W-1:0] = -w[GAIN_W-1:0];
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    logic [CFG_DATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w[LIM_W-1:0] = '0;
      1: w[LIM_W-1:0] = LIM_W'(1);
      2: w[LIM_W-1:0] = LIMIT_RESET;
      3: w[LIM_W-1:0] = '1;
      4: w[LIM_W-1:0] = LIM_W'($urandom_range(0, 100000));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic signed [ERR_W-1:0] pick_error(input spread_t spread, input bit neg);
    logic signed [ERR_W-1:0] e;
    case (spread)
      SPREAD_WINDUP: begin
        e = ERR_W'($urandom_range(24000, 32767));
        if (neg) e = -e;
      end
      SPREAD_SMALL: e = ERR_W'($urandom_range(0, 127)) - ERR_W'(64);
      default: begin
        case ($urandom_range(0, 9))
          0:       e = 16'sh7FFF;
          1:       e = 16'sh8000;
          default: e = ERR_W'($urandom);
        endcase
      end
    endcase
    return e;
  endfunction

  // Sequence: reset, a directed part on the corner cases, then random phases
  // with fresh settings between them, and a final phase with no idling.
  initial begin
    int     ph;
    int     n;
    int     k;
    bit     neg;
    spread_t spread;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero gains give zero drive while the integral still
    // runs into the default limit.
    push_error(16'sh7FFF);
    push_error(16'sh8000);
    wait_quiet();

    // Largest proportional gain, with junk above the gain width: output overflow both ways.
    push_reg(REG_KP, 32'hABCD_7FFF);
    push_error(16'sh7FFF);
    push_error(16'sh8000);
    push_error(16'sh0000);
    push_error(16'sh0001);
    wait_quiet();

    // Unit gain: small negative sums must truncate toward zero, not round down.
    push_reg(REG_KP, 32'h0000_0001);
    push_error(-16'sd1);
    push_error(16'sd4095);
    push_error(-16'sd4097);
    wait_quiet();

    // Most negative derivative gain on the widest error swing.
    push_reg(REG_KP, 32'h0000_0000);
    push_reg(REG_KD, 32'h5A5A_8000);
    push_error(16'sh7FFF);
    push_error(16'sh8000);
    push_error(16'sh7FFF);
    wait_quiet();

    // A zero limit: the stored integral stays at zero, yet each output still
    // sees the error added to it.
    push_reg(REG_KD, 32'h0000_0000);
    push_reg(REG_KI, 32'h0000_0100);
    push_reg(REG_INTEGRAL_LIMIT, 32'h0000_0000);
    push_error(16'sd100);
    push_error(-16'sd50);
    push_error(16'sh7FFF);
    wait_quiet();

    // Widest limit, written with every upper bit set; writes outside the map
    // must not disturb anything. Then let the integral wind up.
    push_reg(REG_INTEGRAL_LIMIT, 32'hFFFF_FFFF);
    push_reg(CFG_IDX_W'(200), 32'hFFFF_FFFF);
    push_reg(CFG_IDX_W'(255), 32'h0000_0000);
    for (k = 0; k < 6; k++) push_error(16'sh7FFF);
    wait_quiet();

    // Limit lowered below the stored integral: the next output uses the
    // unclamped sum and only then does the clamp bite.
    push_reg(REG_INTEGRAL_LIMIT, 32'h0000_03E8);
    push_error(16'sd10);
    push_error(-16'sd10);
    wait_quiet();

    for (ph = 0; ph < 10; ph++) begin
      if (ph == 0 || $urandom_range(0, 3) != 0) push_reg(REG_KP, pick_gain());
      if (ph == 0 || $urandom_range(0, 3) != 0) push_reg(REG_KI, pick_gain());
      if (ph == 0 || $urandom_range(0, 3) != 0) push_reg(REG_KD, pick_gain());
      if (ph == 0 || $urandom_range(0, 3) != 0) push_reg(REG_INTEGRAL_LIMIT, pick_limit());
      if ($urandom_range(0, 2) == 0) begin
        push_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), $urandom);
      end
      // Phase three winds the integral all the way to the widest limit with
      // a modest integral gain so the output is not pinned at saturation.
      if (ph == 3) begin
        push_reg(REG_INTEGRAL_LIMIT, 32'h003F_FFFF);
        push_reg(REG_KI, 32'h0000_0004);
      end
      // Idling: none on every third phase and in the last one, heavy elsewhere.
      idle_odds = (ph % 3 == 1 || ph == 9) ? 0 : 3;
      if (ph == 2) squeeze_req++;
      n   = (ph == 3) ? 170 : 33;
      neg = $urandom_range(0, 1);
      for (k = 0; k < n; k++) begin
        if (ph == 3) spread = SPREAD_WINDUP;
        else if ($urandom_range(0, 2) == 0) spread = SPREAD_SMALL;
        else spread = SPREAD_FULL;
        push_error(pick_error(spread, neg));
      end
      wait_quiet();
    end

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("checked %0d drive words after %0d register writes, with idle bursts,",
             words_checked, regs_written);
    $display("a long output stall, integral windup to the widest limit and lowered limits");
    if (fault_count == 0 && due_drive_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
